/* hw/rtl/fst_pkg.sv */
// fst_pkg: types and constants shared by the frame sequence timer
// holds the item and result beat structs, command codes and register map
// no dependencies
package fst_pkg;

  localparam int TIME_W  = 16;
  localparam int FRAME_W = 8;
  localparam int MODE_W  = 3;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // command codes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_JUMP    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_COUNT    = 2'd1;
  localparam logic [1:0] REG_LOOP     = 2'd2;

  localparam logic [TIME_W-1:0]  INTERVAL_RESET = TIME_W'(100);
  localparam logic [FRAME_W-1:0] COUNT_RESET    = '0;
  localparam logic               LOOP_RESET     = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TIME_W-1:0]  tick_ms;
    logic [FRAME_W-1:0] frame_index;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] shown_frame;
    logic               redraw;
    logic               playing;
    logic [TIME_W-1:0]  elapsed;
  } result_t;

endpackage

/* hw/rtl/frame_sequence_timer.sv */
// frame_sequence_timer: frame sequencer stepped by elapsed-time items
// one shared add/subtract unit under a four-state sequencer
// depends on fst_pkg
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+----------------------
//   item     | item_valid / item_stall          | fst_pkg::item_t
//   result   | result_valid / result_stall      | fst_pkg::result_t
//   config   | psel penable pwrite pready       | paddr, pwdata, prdata
//
// a command that steps no frame goes from S_EXEC straight to S_DONE, which loads the result beat
// a tick on a running sequence does the time add in S_EXEC on one 17-bit adder, then
// one compare-and-subtract per cycle in S_LOOP until the interval no longer fits or a
// one-shot sequence ends, and then loads the result in S_DONE
// one item at a time: item_stall is high from accept until the result is loaded
// a stalled result holds in the output register while the next item is taken
// rst is synchronous and returns the config registers to their reset values
module frame_sequence_timer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  fst_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output fst_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fst_pkg::PADDR_W-1:0]   paddr,
  input  logic [fst_pkg::PDATA_W-1:0]   pwdata,
  output logic [fst_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import fst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOOP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [TIME_W-1:0]  frame_interval;
  logic [FRAME_W-1:0] seq_len;
  logic               loop_enable;
  logic [TIME_W-1:0]  acc;
  logic [FRAME_W-1:0] pos;
  logic [FRAME_W-1:0] pos_before;
  logic               running;
  logic               redraw_flag;
  logic               is_tick;
  item_t              cmd;

  logic               cfg_write;
  logic [1:0]         cfg_idx;
  logic               item_take;
  logic               result_load;
  logic               advance_ok;
  logic               jump_ok;

  // shared unit: add tick time, or subtract interval with carry as compare
  logic               unit_sub;
  logic [TIME_W-1:0]  unit_b;
  logic [TIME_W:0]    unit_sum;
  logic               acc_ge;
  logic [FRAME_W-1:0] pos_inc;

  assign pready     = 1'b1;
  assign cfg_idx    = paddr[3:2];
  assign cfg_write  = psel && penable && pwrite;
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign result_load = (state == S_DONE) && (!result_valid || !result_stall);

  assign advance_ok = running && (seq_len != '0) && (frame_interval != '0);
  assign jump_ok    = (cmd.frame_index < seq_len) && (cmd.frame_index != pos);

  assign unit_sub = (state == S_LOOP);
  assign unit_b   = unit_sub ? ~frame_interval : cmd.tick_ms;
  assign unit_sum = {1'b0, acc} + {1'b0, unit_b} + {{TIME_W{1'b0}}, unit_sub};
  assign acc_ge   = unit_sum[TIME_W];
  assign pos_inc  = pos + FRAME_W'(1);

  always_comb begin
    case (cfg_idx)
      REG_INTERVAL: prdata = PDATA_W'(frame_interval);
      REG_COUNT:    prdata = PDATA_W'(seq_len);
      REG_LOOP:     prdata = PDATA_W'(loop_enable);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval <= INTERVAL_RESET;
      seq_len        <= COUNT_RESET;
      loop_enable    <= LOOP_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_INTERVAL: frame_interval <= pwdata[TIME_W-1:0];
        REG_COUNT:    seq_len        <= pwdata[FRAME_W-1:0];
        REG_LOOP:     loop_enable    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      cmd <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acc          <= '0;
      pos          <= '0;
      pos_before   <= '0;
      running      <= 1'b0;
      redraw_flag  <= 1'b0;
      is_tick      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          is_tick     <= (cmd.mode == MODE_TICK);
          redraw_flag <= (cmd.mode == MODE_RESTART) ||
                         ((cmd.mode == MODE_JUMP) && jump_ok);
          pos_before  <= pos;
          state       <= ((cmd.mode == MODE_TICK) && advance_ok) ? S_LOOP : S_DONE;
          case (cmd.mode)
            MODE_TICK: begin
              if (advance_ok) begin
                acc <= unit_sum[TIME_W-1:0];
              end
            end
            MODE_PLAY: begin
              if (!running) begin
                running <= 1'b1;
                acc     <= '0;
              end
            end
            MODE_STOP: begin
              running <= 1'b0;
            end
            MODE_JUMP: begin
              if (jump_ok) begin
                pos <= cmd.frame_index;
              end
            end
            MODE_RESTART: begin
              pos <= '0;
              acc <= '0;
            end
            default: ;
          endcase
        end
        S_LOOP: begin
          if (!acc_ge) begin
            state <= S_DONE;
          end else if (pos_inc >= seq_len) begin
            if (loop_enable) begin
              acc <= unit_sum[TIME_W-1:0];
              pos <= '0;
            end else begin
              // end of a one-shot sequence: park on the last frame
              pos     <= seq_len - FRAME_W'(1);
              running <= 1'b0;
              acc     <= '0;
              state   <= S_DONE;
            end
          end else begin
            acc <= unit_sum[TIME_W-1:0];
            pos <= pos_inc;
          end
        end
        S_DONE: begin
          if (result_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.shown_frame <= pos;
      result.redraw      <= is_tick ? (pos != pos_before) : redraw_flag;
      result.playing     <= running;
      result.elapsed     <= acc;
    end
  end

endmodule
